/* sv/rgb_led_blink_controller_defines.svh */
// ----------------------------------------------------------------------------
// RGB LED blink controller assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_LED_BLINK_CONTROLLER_DEFINES_SVH
`define RGB_LED_BLINK_CONTROLLER_DEFINES_SVH

// Property that must hold in the same cycle as its antecedent.
`define RGBL_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property whose consequence is checked in the cycle after its antecedent.
`define RGBL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rgbl_pkg.sv */
// ----------------------------------------------------------------------------
// RGB LED blink controller package
// Field widths, request codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbl_pkg;

    localparam int LED_COLOR_W = 24;
    localparam int REQ_W       = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_BLINK_ON_TIME = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_CONT_PERIOD   = 1'b1;

    localparam logic [CFG_DATA_W-1:0] ON_TIME_RESET = 16'd100;
    localparam logic [CFG_DATA_W-1:0] PERIOD_RESET  = 16'd200;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK        = 3'd0,
        REQ_SET_COLOR   = 3'd1,
        REQ_SET_SOLID   = 3'd2,
        REQ_BLINK_ONCE  = 3'd3,
        REQ_BLINK_TWICE = 3'd4,
        REQ_BLINK_CONT  = 3'd5,
        REQ_CLEAR       = 3'd6
    } t_req;

    typedef struct packed {
        logic [LED_COLOR_W-1:0] led_color;
        logic                   led_written;
    } t_result;

endpackage

`default_nettype wire

/* sv/rgbl_skid.sv */
// ----------------------------------------------------------------------------
// RGB LED blink controller output buffer
// Two-entry output register with a skid stage so the upstream stall is a
// registered signal and a new transaction can enter while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_led_blink_controller_defines.svh"

module rgbl_skid #(
    parameter int WIDTH = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [WIDTH-1:0]      o_data
);

    logic             r_out_valid;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_out_data;
    logic [WIDTH-1:0] r_skid_data;
    logic             w_in_acc;
    logic             w_out_take;

    assign w_in_acc   = i_valid && !r_skid_valid;
    assign w_out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                if (!r_out_valid || w_out_take) begin
                    r_out_valid <= 1'b1;
                    r_out_data  <= i_data;
                end else begin
                    r_skid_valid <= 1'b1;
                    r_skid_data  <= i_data;
                end
            end else if (w_out_take) begin
                if (r_skid_valid) begin
                    r_out_data   <= r_skid_data;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    `RGBL_ASSERT(a_skid_behind_out, r_skid_valid, r_out_valid, "skid entry without output entry")
    `RGBL_ASSERT_NEXT(a_stalled_accept_skids, w_in_acc && r_out_valid && i_stall, r_skid_valid, "stalled transaction not held in skid stage")
    `RGBL_ASSERT_NEXT(a_skid_drains_first, r_skid_valid && w_out_take, r_out_data == $past(r_skid_data) && r_out_valid, "skid entry lost on drain")

endmodule

`default_nettype wire

/* sv/rgbl_core.sv */
// ----------------------------------------------------------------------------
// RGB LED blink controller core
// Configuration registers, blink state and the one-pass next-state logic.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rgb_led_blink_controller_defines.svh"

module rgbl_core
    import rgbl_pkg::*;
#(
    parameter int COLOR_BITS = 24,
    parameter int TIMER_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire logic [REQ_W-1:0]      i_req_type,
    input  wire logic [LED_COLOR_W-1:0] i_color,
    output t_result                    o_result
);

    // Bits above the LED field can never be set, so they are not stored.
    localparam int CW    = (COLOR_BITS < LED_COLOR_W) ? COLOR_BITS : LED_COLOR_W;
    localparam int CMP_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;

    typedef enum logic [1:0] {
        MODE_SOLID = 2'd0,
        MODE_ONCE  = 2'd1,
        MODE_TWICE = 2'd2,
        MODE_CONT  = 2'd3
    } t_mode;

    logic [CFG_DATA_W-1:0] r_on_time;
    logic [CFG_DATA_W-1:0] r_period;
    t_mode                 r_mode,     n_mode;
    logic                  r_phase_on, n_phase_on;
    logic [CW-1:0]         r_blink,    n_blink;
    logic [CW-1:0]         r_steady,   n_steady;
    logic [CW-1:0]         r_shown,    n_shown;
    logic [TIMER_BITS-1:0] r_elapsed,  n_elapsed;
    logic                  n_written;

    logic [TIMER_BITS-1:0] w_elapsed_inc;
    logic                  w_on_done;
    logic                  w_period_done;
    logic [CW-1:0]         w_color;

    assign w_color       = i_color[CW-1:0];
    assign w_elapsed_inc = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
    assign w_on_done     = CMP_W'(w_elapsed_inc) >= CMP_W'(r_on_time);
    assign w_period_done = CMP_W'(w_elapsed_inc) >= CMP_W'(r_period);

    always_comb begin
        n_mode     = r_mode;
        n_phase_on = r_phase_on;
        n_blink    = r_blink;
        n_steady   = r_steady;
        n_shown    = r_shown;
        n_elapsed  = r_elapsed;
        n_written  = 1'b0;
        case (i_req_type)
            REQ_TICK: begin
                n_elapsed = w_elapsed_inc;
                if (w_on_done) begin
                    unique case (r_mode)
                        MODE_SOLID: begin
                            n_written = 1'b0;
                        end
                        MODE_CONT: begin
                            if (w_period_done) begin
                                n_phase_on = !r_phase_on;
                                n_elapsed  = '0;
                                n_shown    = r_phase_on ? '0 : r_blink;
                                n_written  = 1'b1;
                            end
                        end
                        MODE_TWICE: begin
                            // Off gap first, then the second flash runs as a single blink.
                            if (r_phase_on) begin
                                n_phase_on = 1'b0;
                                n_shown    = '0;
                            end else begin
                                n_phase_on = 1'b1;
                                n_mode     = MODE_ONCE;
                                n_shown    = r_blink;
                            end
                            n_elapsed = '0;
                            n_written = 1'b1;
                        end
                        MODE_ONCE: begin
                            n_phase_on = 1'b0;
                            n_elapsed  = '0;
                            n_blink    = '0;
                            n_mode     = MODE_SOLID;
                            n_shown    = r_steady;
                            n_written  = 1'b1;
                        end
                    endcase
                end
            end
            REQ_SET_COLOR: begin
                n_steady = w_color;
                if (r_mode == MODE_SOLID) begin
                    n_shown   = w_color;
                    n_written = 1'b1;
                end
            end
            REQ_SET_SOLID: begin
                n_mode    = MODE_SOLID;
                n_steady  = w_color;
                n_shown   = w_color;
                n_written = 1'b1;
            end
            REQ_BLINK_ONCE: begin
                n_mode     = MODE_ONCE;
                n_blink    = w_color;
                n_elapsed  = '0;
                n_phase_on = 1'b1;
                n_shown    = w_color;
                n_written  = 1'b1;
            end
            REQ_BLINK_TWICE: begin
                n_mode     = MODE_TWICE;
                n_blink    = w_color;
                n_elapsed  = '0;
                n_phase_on = 1'b1;
                n_shown    = w_color;
                n_written  = 1'b1;
            end
            REQ_BLINK_CONT: begin
                n_mode     = MODE_CONT;
                n_blink    = w_color;
                n_elapsed  = '0;
                n_phase_on = 1'b1;
                n_shown    = w_color;
                n_written  = 1'b1;
            end
            REQ_CLEAR: begin
                n_mode     = MODE_SOLID;
                n_phase_on = 1'b0;
                n_blink    = '0;
                n_elapsed  = '0;
                n_steady   = '0;
                n_shown    = '0;
                n_written  = 1'b1;
            end
            default: begin
                n_written = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time  <= ON_TIME_RESET;
            r_period   <= PERIOD_RESET;
            r_mode     <= MODE_SOLID;
            r_phase_on <= 1'b0;
            r_blink    <= '0;
            r_steady   <= '0;
            r_shown    <= '0;
            r_elapsed  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    REG_BLINK_ON_TIME: r_on_time <= i_cfg_data;
                    REG_CONT_PERIOD:   r_period  <= i_cfg_data;
                    default: begin
                        r_on_time <= r_on_time;
                    end
                endcase
            end
            if (i_accept) begin
                r_mode     <= n_mode;
                r_phase_on <= n_phase_on;
                r_blink    <= n_blink;
                r_steady   <= n_steady;
                r_shown    <= n_shown;
                r_elapsed  <= n_elapsed;
            end
        end
    end

    assign o_result.led_color   = LED_COLOR_W'(n_shown);
    assign o_result.led_written = n_written;

    `RGBL_ASSERT(a_once_is_on, r_mode == MODE_ONCE, r_phase_on, "single blink in off phase")
    `RGBL_ASSERT_NEXT(a_blink_restarts_timer, i_accept && (i_req_type == REQ_BLINK_ONCE || i_req_type == REQ_BLINK_TWICE || i_req_type == REQ_BLINK_CONT), r_elapsed == '0 && r_phase_on, "blink start did not restart timer")
    `RGBL_ASSERT_NEXT(a_clear_to_black, i_accept && i_req_type == REQ_CLEAR, r_shown == '0 && r_steady == '0 && r_mode == MODE_SOLID, "clear left color or mode behind")

endmodule

`default_nettype wire

/* sv/rgb_led_blink_controller.sv */
// A result is registered into the output buffer when its transaction is accepted.
// Throughput: one transaction per cycle while o_stall is low; the next-state logic is a single pass.
// A two-entry output buffer keeps input acceptance going while one result waits.
// o_stall rises only when both output entries are full.
// Reset (synchronous, active low) returns to solid black, timer 0, on-time 100,
// period 200; no clearing pass is needed.
`default_nettype none

// ----------------------------------------------------------------------------
// RGB LED blink controller
// Solid, single, double and continuous blink control of one RGB LED color.
// ----------------------------------------------------------------------------
module rgb_led_blink_controller
    import rgbl_pkg::*;
#(
    parameter int COLOR_BITS = 24,
    parameter int TIMER_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [REQ_W-1:0]       i_req_type,
    input  wire logic [LED_COLOR_W-1:0] i_color,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [LED_COLOR_W-1:0]      o_led_color,
    output logic                        o_led_written
);

    t_result w_res_in;
    t_result w_res_out;
    logic    w_in_acc;

    assign w_in_acc = i_valid && !o_stall;

    rgbl_core #(
        .COLOR_BITS(COLOR_BITS),
        .TIMER_BITS(TIMER_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_accept   (w_in_acc),
        .i_req_type (i_req_type),
        .i_color    (i_color),
        .o_result   (w_res_in)
    );

    rgbl_skid #(
        .WIDTH($bits(t_result))
    ) u_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (w_res_in),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (w_res_out)
    );

    assign o_led_color   = w_res_out.led_color;
    assign o_led_written = w_res_out.led_written;

endmodule

`default_nettype wire

/* test/led_color_checker.sv */
// ----------------------------------------------------------------------------
// LED color checker
// Watches the request, result and register ports of the blink controller,
// predicts the LED color and write flag of every accepted request, and
// compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module led_color_checker
    import rgbl_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [REQ_W-1:0]       i_req_type,
    input  logic [LED_COLOR_W-1:0] i_color,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [LED_COLOR_W-1:0] i_led_color,
    input  logic                   i_led_written,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_checked
);

    typedef enum logic [1:0] {
        MODE_SOLID,
        MODE_ONCE,
        MODE_TWICE,
        MODE_CONT
    } t_led_mode;

    localparam logic [CFG_DATA_W-1:0] ELAPSED_MAX = '1;

    logic [CFG_DATA_W-1:0]  on_time;
    logic [CFG_DATA_W-1:0]  period;
    t_led_mode              mode;
    logic                   phase_on;
    logic [LED_COLOR_W-1:0] blink_col;
    logic [LED_COLOR_W-1:0] steady_col;
    logic [LED_COLOR_W-1:0] shown_col;
    logic [CFG_DATA_W-1:0]  elapsed;

    t_result led_results[$];

    // One millisecond passes; returns 1 when a blink stepped on.
    function automatic logic advance_ms();
        logic stepped;
        stepped = 1'b0;
        if (elapsed != ELAPSED_MAX) begin
            elapsed = elapsed + 1'b1;
        end
        if (mode != MODE_SOLID && elapsed >= on_time) begin
            case (mode)
                MODE_CONT: begin
                    if (elapsed >= period) begin
                        phase_on  = !phase_on;
                        elapsed   = '0;
                        shown_col = phase_on ? blink_col : '0;
                        stepped   = 1'b1;
                    end
                end
                MODE_TWICE: begin
                    // The off gap of a double blink is followed by one last
                    // on phase, which then ends like a single blink.
                    if (phase_on) begin
                        phase_on  = 1'b0;
                        shown_col = '0;
                    end else begin
                        phase_on  = 1'b1;
                        mode      = MODE_ONCE;
                        shown_col = blink_col;
                    end
                    elapsed = '0;
                    stepped = 1'b1;
                end
                default: begin
                    phase_on  = 1'b0;
                    elapsed   = '0;
                    blink_col = '0;
                    mode      = MODE_SOLID;
                    shown_col = steady_col;
                    stepped   = 1'b1;
                end
            endcase
        end
        return stepped;
    endfunction

    function automatic void start_blink(input logic [LED_COLOR_W-1:0] col,
                                        input t_led_mode m);
        mode      = m;
        blink_col = col;
        elapsed   = '0;
        phase_on  = 1'b1;
        shown_col = col;
    endfunction

    function automatic t_result next_led(input logic [REQ_W-1:0] req,
                                         input logic [LED_COLOR_W-1:0] col);
        t_result res;
        logic    written;
        written = 1'b0;
        case (req)
            REQ_TICK: begin
                written = advance_ms();
            end
            REQ_SET_COLOR: begin
                steady_col = col;
                if (mode == MODE_SOLID) begin
                    shown_col = col;
                    written   = 1'b1;
                end
            end
            REQ_SET_SOLID: begin
                mode       = MODE_SOLID;
                steady_col = col;
                shown_col  = col;
                written    = 1'b1;
            end
            REQ_BLINK_ONCE: begin
                start_blink(col, MODE_ONCE);
                written = 1'b1;
            end
            REQ_BLINK_TWICE: begin
                start_blink(col, MODE_TWICE);
                written = 1'b1;
            end
            REQ_BLINK_CONT: begin
                start_blink(col, MODE_CONT);
                written = 1'b1;
            end
            REQ_CLEAR: begin
                mode       = MODE_SOLID;
                phase_on   = 1'b0;
                blink_col  = '0;
                elapsed    = '0;
                steady_col = '0;
                shown_col  = '0;
                written    = 1'b1;
            end
            default: begin
            end
        endcase
        res.led_color   = shown_col;
        res.led_written = written;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            on_time    = ON_TIME_RESET;
            period     = PERIOD_RESET;
            mode       = MODE_SOLID;
            phase_on   = 1'b0;
            blink_col  = '0;
            steady_col = '0;
            shown_col  = '0;
            elapsed    = '0;
            led_results.delete();
            o_errors   = 0;
            o_checked  = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_addr)
                    REG_BLINK_ON_TIME: on_time = i_cfg_data;
                    REG_CONT_PERIOD:   period  = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            // A result always belongs to an earlier transaction, so it is
            // checked before this cycle's request is predicted.
            if (i_out_valid && !i_out_stall) begin
                if (led_results.size() == 0) begin
                    $error("unexpected result: led_color %06h, led_written %0b",
                           i_led_color, i_led_written);
                    o_errors = o_errors + 1;
                end else begin
                    want = led_results.pop_front();
                    if (i_led_color !== want.led_color) begin
                        $error("led_color: expected %06h, got %06h",
                               want.led_color, i_led_color);
                        o_errors = o_errors + 1;
                    end
                    if (i_led_written !== want.led_written) begin
                        $error("led_written: expected %0b, got %0b",
                               want.led_written, i_led_written);
                        o_errors = o_errors + 1;
                    end
                    o_checked = o_checked + 1;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                led_results.push_back(next_led(i_req_type, i_color));
            end
        end
        o_pending = led_results.size();
    end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// RGB LED blink controller testbench
// Drives directed and random request streams through several blink timing
// settings with random idle cycles on both channels, and leaves the checking
// to the LED color checker instantiated beside the controller.
// ----------------------------------------------------------------------------
module testbench;
    import rgbl_pkg::*;

    // Request code 7 has no meaning; the controller must ignore it.
    localparam logic [REQ_W-1:0] REQ_RESERVED = 3'd7;
    localparam int               IDLE_PCT     = 36;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;
    logic                   i_valid     = 1'b0;
    logic [REQ_W-1:0]       i_req_type  = '0;
    logic [LED_COLOR_W-1:0] i_color     = '0;
    logic                   i_stall     = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [LED_COLOR_W-1:0] o_led_color;
    logic                   o_led_written;

    logic calm = 1'b0;
    int   errors;
    int   pending;
    int   checked;
    int   n_sent     = 0;
    int   n_settings = 0;

    rgb_led_blink_controller uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_color       (i_color),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_led_color   (o_led_color),
        .o_led_written (o_led_written)
    );

    led_color_checker led_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_req_type    (i_req_type),
        .i_color       (i_color),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_led_color   (o_led_color),
        .i_led_written (o_led_written),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    function automatic logic [LED_COLOR_W-1:0] random_color();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return LED_COLOR_W'($urandom);
        endcase
    endfunction

    // Blink starts dominate so that the timed steps are reached often.
    function automatic logic [REQ_W-1:0] pick_command();
        case ($urandom_range(0, 9))
            0, 1:    return REQ_BLINK_ONCE;
            2, 3:    return REQ_BLINK_TWICE;
            4, 5:    return REQ_BLINK_CONT;
            6:       return REQ_SET_COLOR;
            7:       return REQ_SET_SOLID;
            8:       return REQ_CLEAR;
            default: return REQ_RESERVED;
        endcase
    endfunction

    // Called at a rising edge; returns at the edge that accepts the request.
    task automatic send_item(input logic [REQ_W-1:0] req,
                             input logic [LED_COLOR_W-1:0] col);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_color    <= col;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        n_sent++;
    endtask

    // Stops sending and waits until every predicted result has been seen.
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_timing(input logic [CFG_DATA_W-1:0] on_ms,
                              input logic [CFG_DATA_W-1:0] period_ms);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= REG_BLINK_ON_TIME;
        i_cfg_data  <= on_ms;
        @(posedge i_clk);
        i_cfg_addr  <= REG_CONT_PERIOD;
        i_cfg_data  <= period_ms;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Mostly a command followed by a run of ticks, with some loose noise.
    task automatic run_sequences(input int n_items, input int tick_span);
        int sent;
        int n_ticks;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 15) begin
                send_item(REQ_W'($urandom_range(0, 7)), random_color());
                sent++;
            end else begin
                send_item(pick_command(), random_color());
                n_ticks = $urandom_range(0, tick_span);
                repeat (n_ticks) send_item(REQ_TICK, random_color());
                sent += n_ticks + 1;
            end
            if ($urandom_range(0, 99) < 3) begin
                drain();
            end
        end
    endtask

    initial begin
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n_settings = 1;

        // Directed commands at the reset timing.
        send_item(REQ_TICK, 24'hFFFFFF);
        send_item(REQ_SET_COLOR, 24'hFFFFFF);
        send_item(REQ_SET_COLOR, 24'h000000);
        send_item(REQ_SET_SOLID, 24'h800001);
        send_item(REQ_BLINK_ONCE, 24'h00FF00);
        send_item(REQ_SET_COLOR, 24'h0000FF);
        send_item(REQ_TICK, 24'h000000);
        send_item(REQ_RESERVED, 24'hFFFFFF);
        send_item(REQ_SET_SOLID, 24'h123456);
        send_item(REQ_BLINK_TWICE, 24'hFFFFFF);
        send_item(REQ_SET_COLOR, 24'hABCDEF);
        send_item(REQ_BLINK_CONT, 24'h000001);
        send_item(REQ_TICK, 24'h5A5A5A);
        send_item(REQ_CLEAR, 24'hFFFFFF);
        send_item(REQ_RESERVED, 24'h000000);
        send_item(REQ_SET_COLOR, 24'h7FFFFF);
        send_item(REQ_BLINK_ONCE, 24'h000000);
        send_item(REQ_CLEAR, 24'h000000);

        // Reset durations need long tick runs to reach each step.
        run_sequences(220, 210);

        set_timing(16'd1, 16'd1);
        run_sequences(120, 4);

        // Zero durations count as passed on the very next tick.
        set_timing(16'd0, 16'd0);
        run_sequences(100, 3);

        // Full-scale on time, sent without any idling on either side.
        // The blink holds its phase for the whole run of ticks.
        set_timing(16'hFFFF, 16'd1);
        calm <= 1'b1;
        send_item(REQ_BLINK_CONT, 24'hFFFFFF);
        repeat (100) send_item(REQ_TICK, random_color());
        send_item(REQ_BLINK_ONCE, 24'h55AA55);
        repeat (3) send_item(REQ_TICK, random_color());
        run_sequences(60, 3);
        calm <= 1'b0;

        set_timing(16'd1, 16'hFFFF);
        run_sequences(60, 5);

        for (k = 0; k < 4; k++) begin
            set_timing(CFG_DATA_W'($urandom_range(1, 12)),
                       CFG_DATA_W'($urandom_range(1, 12)));
            run_sequences(60, 30);
        end

        drain();
        repeat (5) @(posedge i_clk);
        $display("Sent %0d transactions under %0d timing settings; %0d results compared.",
                 n_sent, n_settings, checked);
        $display("Covered every request code, the unused code, zero and full-scale durations.");
        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
